@@ sv/lirm_pkg.sv @@
`default_nettype none
package lirm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 17;
  localparam int STEP_W     = 16;
  localparam int GAIN_W     = 8;
  localparam int GAIN_SHIFT = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP        = 2'd0,
    REG_STEREO_MODE = 2'd1,
    REG_GAIN_LEFT   = 2'd2,
    REG_GAIN_RIGHT  = 2'd3
  } reg_idx_t;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd128;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              stereo_mode;
    logic [GAIN_W-1:0] gain_left;
    logic [GAIN_W-1:0] gain_right;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic prime;    // store the incoming word as the previous frame
    logic skip;     // empty run: previous frame from the input, phase drops by one
    logic capture;  // hold the incoming word as the current frame
    logic lerp;     // register the interpolation products
    logic gain;     // register the gain products and advance the phase
    logic emit;     // load the output register
    logic last;     // run_end value for the word being emitted
    logic finish;   // close the run: current frame becomes previous, rebase phase
  } cmd_t;

  typedef struct packed {
    logic below_one;  // phase is still before the current frame
  } status_t;

endpackage
`default_nettype wire

@@ sv/lirm_ctrl.sv @@
`default_nettype none
module lirm_ctrl #(
  parameter int MAX_RUN = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  lirm_pkg::status_t   status,
  output lirm_pkg::cmd_t      cmd
);
  import lirm_pkg::*;

  localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RUN - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LERP = 4'b0010,
    S_GAIN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             primed, primed_next;
  logic             out_free;
  logic             last;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign last     = (count == CNT_LAST) || !status.below_one;

  always_comb begin
    state_next  = state;
    count_next  = count;
    primed_next = primed;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!primed) begin
            cmd.prime   = 1'b1;
            primed_next = 1'b1;
          end else if (!status.below_one) begin
            cmd.skip = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            count_next  = '0;
            state_next  = S_LERP;
          end
        end
      end
      S_LERP: begin
        cmd.lerp   = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.last = last;
          if (last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            count_next = count + CNT_W'(1);
            state_next = S_LERP;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      primed <= primed_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/lirm_dp.sv @@
`default_nettype none
module lirm_dp #(
  parameter int FRAC_BITS = 12
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  lirm_pkg::cfg_t                       cfg,
  input  wire signed [lirm_pkg::SAMPLE_W-1:0]  left_sample,
  input  wire signed [lirm_pkg::SAMPLE_W-1:0]  right_sample,
  input  lirm_pkg::cmd_t                       cmd,
  output lirm_pkg::status_t                    status,
  output logic signed [lirm_pkg::SAMPLE_W-1:0] left_mix,
  output logic signed [lirm_pkg::SAMPLE_W-1:0] right_mix,
  output logic                                 run_end
);
  import lirm_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int GPROD_W = SAMPLE_W + GAIN_W + 1;
  localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FRAC_BITS;

  logic signed [SAMPLE_W-1:0] prev_left, prev_right;
  logic signed [SAMPLE_W-1:0] cur_left, cur_right;
  logic [PHASE_W-1:0]         phase;

  logic signed [DIFF_W-1:0]   diff_left, diff_right;
  logic signed [FRAC_BITS:0]  frac;
  logic signed [PROD_W-1:0]   prod_left, prod_right;
  logic signed [PROD_W-1:0]   shr_left, shr_right;
  logic signed [SAMPLE_W-1:0] interp_left, interp_right, interp_right_sel;
  logic signed [GAIN_W:0]     gl, gr;
  logic signed [GPROD_W-1:0]  gprod_left, gprod_right;

  assign status.below_one = (phase[PHASE_W-1:FRAC_BITS] == '0);

  assign frac       = signed'({1'b0, phase[FRAC_BITS-1:0]});
  assign diff_left  = DIFF_W'(cur_left) - DIFF_W'(prev_left);
  assign diff_right = DIFF_W'(cur_right) - DIFF_W'(prev_right);

  // Arithmetic shift gives the floor; the sum stays between the two frames.
  assign shr_left         = prod_left >>> FRAC_BITS;
  assign shr_right        = prod_right >>> FRAC_BITS;
  assign interp_left      = prev_left + shr_left[SAMPLE_W-1:0];
  assign interp_right     = prev_right + shr_right[SAMPLE_W-1:0];
  assign interp_right_sel = cfg.stereo_mode ? interp_right : interp_left;
  assign gl               = signed'({1'b0, cfg.gain_left});
  assign gr               = signed'({1'b0, cfg.gain_right});

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
      phase      <= '0;
    end else begin
      if (cmd.prime || cmd.skip) begin
        prev_left  <= left_sample;
        prev_right <= right_sample;
      end
      if (cmd.finish) begin
        prev_left  <= cur_left;
        prev_right <= cur_right;
      end
      if (cmd.skip) begin
        phase <= phase - ONE;
      end
      if (cmd.gain) begin
        phase <= phase + PHASE_W'(cfg.step);
      end
      if (cmd.finish) begin
        phase <= status.below_one ? '0 : phase - ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_left  <= left_sample;
      cur_right <= right_sample;
    end
    if (cmd.lerp) begin
      prod_left  <= PROD_W'(diff_left * frac);
      prod_right <= PROD_W'(diff_right * frac);
    end
    if (cmd.gain) begin
      gprod_left  <= GPROD_W'(interp_left * gl);
      gprod_right <= GPROD_W'(interp_right_sel * gr);
    end
    if (cmd.emit) begin
      left_mix  <= gprod_left[GAIN_SHIFT +: SAMPLE_W];
      right_mix <= gprod_right[GAIN_SHIFT +: SAMPLE_W];
      run_end   <= cmd.last;
    end
  end

endmodule
`default_nettype wire

@@ sv/linear_interp_resample_mixer_unit.sv @@
`default_nettype none
// Linear-interpolation resampler with per-side gain. Each accepted input word is one
// source frame; the first frame after reset only primes the block. Every later frame
// yields one output word per output position between the previous frame and this one
// (at most MAX_RUN), with run_end set on the last of them; a frame that falls between
// two output positions yields none. The phase step is Q(16-FRAC_BITS).FRAC_BITS. A
// priming or empty frame is dealt with as it is taken; a frame with outputs is taken
// first, then each output passes in turn through the interpolation multiplies, the gain
// multiplies and the output register, where an output stall holds it.
// The next frame is taken as soon as the last word of a run sits in the output register.
// Configuration writes take effect at once.
module linear_interp_resample_mixer_unit #(
  parameter int FRAC_BITS = 12,
  parameter int MAX_RUN   = 16
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_write,
  input  wire [lirm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [lirm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire signed [lirm_pkg::SAMPLE_W-1:0]    left_sample,
  input  wire signed [lirm_pkg::SAMPLE_W-1:0]    right_sample,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [lirm_pkg::SAMPLE_W-1:0]   left_mix,
  output logic signed [lirm_pkg::SAMPLE_W-1:0]   right_mix,
  output logic                                   run_end
);
  import lirm_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step        <= STEP_RESET;
      cfg.stereo_mode <= 1'b0;
      cfg.gain_left   <= GAIN_RESET;
      cfg.gain_right  <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP:        cfg.step        <= cfg_data[STEP_W-1:0];
        REG_STEREO_MODE: cfg.stereo_mode <= cfg_data[0];
        REG_GAIN_LEFT:   cfg.gain_left   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_RIGHT:  cfg.gain_right  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lirm_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lirm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .cmd          (cmd),
    .status       (status),
    .left_mix     (left_mix),
    .right_mix    (right_mix),
    .run_end      (run_end)
  );

endmodule
`default_nettype wire

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lirm_pkg::*;

  localparam int FRAC_BITS = 12;
  localparam int MAX_RUN   = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int ITEMS     = 420;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } mix_word_t;

  class mix_scoreboard;
    logic [STEP_W-1:0]          step;
    logic                       stereo;
    logic [GAIN_W-1:0]          gain_l;
    logic [GAIN_W-1:0]          gain_r;
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] prev_r;
    logic [PHASE_W-1:0]         phase;
    bit                         primed;
    mix_word_t                  expected[$];
    int                         errors;

    function new();
      step   = STEP_RESET;
      stereo = 1'b0;
      gain_l = GAIN_RESET;
      gain_r = GAIN_RESET;
      prev_l = '0;
      prev_r = '0;
      phase  = '0;
      primed = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STEP:        step   = val[STEP_W-1:0];
        REG_STEREO_MODE: stereo = val[0];
        REG_GAIN_LEFT:   gain_l = val[GAIN_W-1:0];
        REG_GAIN_RIGHT:  gain_r = val[GAIN_W-1:0];
      endcase
    endfunction

    // Floor of the product shifted right, as an arithmetic shift of a wide signed value.
    function int interp(int a, int b, logic [PHASE_W-1:0] frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(frac);
      return a + int'(prod >>> FRAC_BITS);
    endfunction

    function logic [SAMPLE_W-1:0] scale(int s, logic [GAIN_W-1:0] g);
      longint prod;
      prod = longint'(s) * longint'(g);
      return SAMPLE_W'(prod >>> GAIN_SHIFT);
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] cur_l,
                             logic signed [SAMPLE_W-1:0] cur_r);
      int        n;
      int        sl;
      int        sr;
      mix_word_t w;
      if (!primed) begin
        primed = 1'b1;
        prev_l = cur_l;
        prev_r = cur_r;
        return;
      end
      n = 0;
      while (phase < ONE && n < MAX_RUN) begin
        sl = interp(prev_l, cur_l, phase);
        sr = stereo ? interp(prev_r, cur_r, phase) : sl;
        w.left  = scale(sl, gain_l);
        w.right = scale(sr, gain_r);
        n++;
        phase  = phase + step;
        w.last = (phase >= ONE) || (n == MAX_RUN);
        expected.push_back(w);
      end
      // A run cut short by the cap restarts on the new frame.
      if (phase >= ONE)
        phase = phase - ONE;
      else
        phase = '0;
      prev_l = cur_l;
      prev_r = cur_r;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                      logic e);
      mix_word_t w;
      if (expected.size() == 0) begin
        report($sformatf("unexpected word left %0d right %0d run_end %0b", l, r, e));
        return;
      end
      w = expected.pop_front();
      if (l !== w.left)
        report($sformatf("left_mix %0d, expected %0d", l, w.left));
      if (r !== w.right)
        report($sformatf("right_mix %0d, expected %0d", r, w.right));
      if (e !== w.last)
        report($sformatf("run_end %0b, expected %0b", e, w.last));
    endtask
  endclass

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_write    = 1'b0;
  reg_idx_t                   cfg_index    = REG_STEP;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] left_sample  = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] left_mix;
  logic signed [SAMPLE_W-1:0] right_mix;
  logic                       run_end;

  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  int sent      = 0;

  mix_scoreboard sb = new();

  linear_interp_resample_mixer_unit #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_RUN  (MAX_RUN)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .left_sample (left_sample),
    .right_sample(right_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_mix    (left_mix),
    .right_mix   (right_mix),
    .run_end     (run_end)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Valid stays high from one word to the next; only an idle burst or a drain lowers it.
  task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (in_stall);
    sb.note_frame(l, r);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Empty and priming frames give no result, so drain waits on after the queue empties.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Junk in the unused upper bits of the narrow registers must be ignored.
  task automatic apply_config(logic [STEP_W-1:0] step, logic stereo,
                              logic [GAIN_W-1:0] gl, logic [GAIN_W-1:0] gr);
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    idx = idx.first();
    do begin
      case (idx)
        REG_STEP:        val = step;
        REG_STEREO_MODE: val = {15'($urandom), stereo};
        REG_GAIN_LEFT:   val = {8'($urandom), gl};
        REG_GAIN_RIGHT:  val = {8'($urandom), gr};
      endcase
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      sb.set_reg(idx, val);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3, 4: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 15))
      0, 1:    return 16'd256;
      2:       return 16'hFFFF;
      3:       return STEP_W'($urandom_range(1, 255));
      4:       return STEP_W'($urandom_range(8192, 65535));
      default: return STEP_W'($urandom_range(512, 8192));
    endcase
  endfunction

  // Receiver: checks every accepted word and plans the stall for the next cycle.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall)
        sb.check_result(left_mix, right_mix, run_end);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 300;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int frames;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings; the first frame only primes.
    send_frame(16'sh8000, 16'sh7FFF); maybe_idle();
    send_frame(16'sh7FFF, 16'sh8000); maybe_idle();
    send_frame(16'sh8000, 16'sh7FFF); maybe_idle();
    send_frame(16'sh0000, 16'sh0000); maybe_idle();
    send_frame(16'shFFFF, 16'shFFFF); maybe_idle();
    drain();

    // Stereo with full and zero gain, four outputs per frame.
    apply_config(16'd1024, 1'b1, 8'd255, 8'd0);
    send_frame(16'sh7FFF, 16'sh8000); maybe_idle();
    send_frame(16'sh8000, 16'sh7FFF); maybe_idle();
    send_frame(16'sd12345, -16'sd12345); maybe_idle();
    drain();

    // Mono after stereo; the run fills the cap exactly as the phase reaches one.
    apply_config(16'd256, 1'b0, 8'd0, 8'd255);
    send_frame(16'sh8000, 16'sd100); maybe_idle();
    send_frame(16'sh7FFF, -16'sd100); maybe_idle();
    send_frame(16'shFFFF, 16'sd5); maybe_idle();
    drain();

    // Step too small to reach the next frame within the cap, back in stereo.
    apply_config(16'd200, 1'b1, 8'd255, 8'd255);
    send_frame(16'sh7FFF, 16'sh8000); maybe_idle();
    send_frame(16'sh8000, 16'sh7FFF); maybe_idle();
    drain();

    // Largest step: mostly empty runs.
    apply_config(16'hFFFF, 1'b0, 8'd128, 8'd200);
    repeat (6) begin
      send_frame(pick_sample(), pick_sample());
      maybe_idle();
    end
    drain();

    apply_config(16'd6000, 1'b1, 8'd77, 8'd181);
    repeat (5) begin
      send_frame(pick_sample(), pick_sample());
      maybe_idle();
    end
    drain();

    while (sent < ITEMS) begin
      apply_config(pick_step(), 1'($urandom), 8'($urandom), 8'($urandom));
      frames = $urandom_range(10, 40);
      while (frames > 0 && sent < ITEMS) begin
        send_frame(pick_sample(), pick_sample());
        sent++;
        frames--;
        if (sent == 150)
          hold_req = 1'b1;
        if (sent == 300)
          drain();
        quiet = (sent >= ITEMS - 60);
        maybe_idle();
      end
      drain();
    end

    in_valid <= 1'b0;
    for (int i = 0; i < 50000 && sb.pending() != 0; i++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected words never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
